>>> sv/dpq_pkg.sv
// Shared constants, types, gamma table and error arithmetic for the palette quantizer.
package dpq_pkg;

	localparam int MAX_LINE_WIDTH = 1024;
	localparam int COL_BITS       = $clog2(MAX_LINE_WIDTH);
	localparam int WID_BITS       = COL_BITS + 1;
	localparam int PAL_ENTRIES    = 256;
	localparam int PAL_BITS       = $clog2(PAL_ENTRIES);
	localparam int ERR_BITS       = 10;
	localparam int ERR_W          = 3 * ERR_BITS;
	localparam int COST_BITS      = 11;

	localparam logic signed [ERR_BITS-1:0] ERR_HI = {1'b0, {(ERR_BITS-1){1'b1}}};
	localparam logic signed [ERR_BITS-1:0] ERR_LO = {1'b1, {(ERR_BITS-1){1'b0}}};

	// configuration register indexes
	localparam logic [1:0] CFG_GREYSCALE = 2'd0;
	localparam logic [1:0] CFG_DIRECT    = 2'd1;
	localparam logic [1:0] CFG_WIDTH     = 2'd2;
	localparam logic [1:0] CFG_PSIZE     = 2'd3;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	// Floyd-Steinberg weights in sixteenths
	localparam logic [3:0] W_RIGHT  = 4'd7;
	localparam logic [3:0] W_BLEFT  = 4'd3;
	localparam logic [3:0] W_BELOW  = 4'd5;
	localparam logic [3:0] W_BRIGHT = 4'd1;

	typedef enum logic [13:0] {
		S_CLEAR  = 14'b00000000000001,
		S_IDLE   = 14'b00000000000010,
		S_RDERR  = 14'b00000000000100,
		S_DA     = 14'b00000000001000,
		S_PREP   = 14'b00000000010000,
		S_SEARCH = 14'b00000000100000,
		S_RESID  = 14'b00000001000000,
		S_DRD1   = 14'b00000010000000,
		S_DWR1   = 14'b00000100000000,
		S_DRD2   = 14'b00001000000000,
		S_DWR2   = 14'b00010000000000,
		S_DRD3   = 14'b00100000000000,
		S_DWR3   = 14'b01000000000000,
		S_OUT    = 14'b10000000000000
	} state_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] y;
		logic       grey;
	} cost_in_t;

	localparam logic [7:0] GAMMA [256] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01,
		8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h02, 8'h02, 8'h02,
		8'h02, 8'h02, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h04,
		8'h04, 8'h04, 8'h04, 8'h05, 8'h05, 8'h05, 8'h05, 8'h06,
		8'h06, 8'h06, 8'h07, 8'h07, 8'h07, 8'h08, 8'h08, 8'h08,
		8'h09, 8'h09, 8'h09, 8'h0A, 8'h0A, 8'h0A, 8'h0B, 8'h0B,
		8'h0C, 8'h0C, 8'h0D, 8'h0D, 8'h0D, 8'h0E, 8'h0E, 8'h0F,
		8'h0F, 8'h10, 8'h10, 8'h11, 8'h11, 8'h12, 8'h12, 8'h13,
		8'h13, 8'h14, 8'h15, 8'h15, 8'h16, 8'h16, 8'h17, 8'h17,
		8'h18, 8'h19, 8'h19, 8'h1A, 8'h1B, 8'h1B, 8'h1C, 8'h1D,
		8'h1D, 8'h1E, 8'h1F, 8'h1F, 8'h20, 8'h21, 8'h21, 8'h22,
		8'h23, 8'h24, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h28,
		8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2D, 8'h2E, 8'h2F,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h37, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
		8'h3F, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
		8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4D, 8'h4E, 8'h4F, 8'h50,
		8'h51, 8'h52, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h5A,
		8'h5B, 8'h5C, 8'h5D, 8'h5F, 8'h60, 8'h61, 8'h63, 8'h64,
		8'h65, 8'h67, 8'h68, 8'h69, 8'h6B, 8'h6C, 8'h6D, 8'h6F,
		8'h70, 8'h72, 8'h73, 8'h75, 8'h76, 8'h77, 8'h79, 8'h7A,
		8'h7C, 8'h7D, 8'h7F, 8'h80, 8'h82, 8'h83, 8'h85, 8'h87,
		8'h88, 8'h8A, 8'h8B, 8'h8D, 8'h8E, 8'h90, 8'h92, 8'h93,
		8'h95, 8'h97, 8'h98, 8'h9A, 8'h9C, 8'h9D, 8'h9F, 8'hA1,
		8'hA2, 8'hA4, 8'hA6, 8'hA8, 8'hA9, 8'hAB, 8'hAD, 8'hAF,
		8'hB0, 8'hB2, 8'hB4, 8'hB6, 8'hB8, 8'hBA, 8'hBB, 8'hBD,
		8'hBF, 8'hC1, 8'hC3, 8'hC5, 8'hC7, 8'hC9, 8'hCB, 8'hCD,
		8'hCF, 8'hD1, 8'hD3, 8'hD5, 8'hD7, 8'hD9, 8'hDB, 8'hDD,
		8'hDF, 8'hE1, 8'hE3, 8'hE5, 8'hE7, 8'hE9, 8'hEB, 8'hED,
		8'hEF, 8'hF1, 8'hF4, 8'hF6, 8'hF8, 8'hFA, 8'hFC, 8'hFF
	};

	// weighted share of an error, truncated toward zero
	function automatic logic signed [ERR_BITS-1:0] share(
		input logic signed [ERR_BITS-1:0] e,
		input logic [3:0] w
	);
		logic [ERR_BITS:0]   mag;
		logic [ERR_BITS+4:0] prod;
		logic [ERR_BITS:0]   m;
		mag  = e[ERR_BITS-1] ? ((ERR_BITS+1)'(0) - {e[ERR_BITS-1], e}) : {1'b0, e};
		prod = (ERR_BITS+5)'(mag) * (ERR_BITS+5)'(w);
		m    = prod[ERR_BITS+4:4];
		return e[ERR_BITS-1] ? ERR_BITS'((ERR_BITS+1)'(0) - m) : ERR_BITS'(m);
	endfunction

	function automatic logic signed [ERR_BITS-1:0] sat_add(
		input logic signed [ERR_BITS-1:0] a,
		input logic signed [ERR_BITS-1:0] b
	);
		logic signed [ERR_BITS:0] s;
		s = (ERR_BITS+1)'(a) + (ERR_BITS+1)'(b);
		if (s > (ERR_BITS+1)'(ERR_HI))
			return ERR_HI;
		if (s < (ERR_BITS+1)'(ERR_LO))
			return ERR_LO;
		return ERR_BITS'(s);
	endfunction

	// add the weighted residual to each channel of a stored error word
	function automatic logic [ERR_W-1:0] spread(
		input logic [ERR_W-1:0] word,
		input logic [ERR_W-1:0] res,
		input logic [3:0] w
	);
		logic [ERR_W-1:0] o;
		o = '0;
		for (int c = 0; c < 3; c++)
			o[c*ERR_BITS +: ERR_BITS] = sat_add(word[c*ERR_BITS +: ERR_BITS],
				share(res[c*ERR_BITS +: ERR_BITS], w));
		return o;
	endfunction

endpackage

>>> sv/dithering_palette_quantizer_core.sv
// Palette quantizer with gamma, Floyd-Steinberg error diffusion and RGB565 bypass.
//
// Request channel (req_valid / req_stall): req_type 0 writes palette entry
// entry_index with red/green/blue/luma and yields no result; req_type 1 is a
// pixel in raster order. frame_start on a pixel restarts column and error lines.
// Result channel (res_valid / res_stall): one pixel_code and row_end per pixel.
// Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are always
// taken; change them only while the block is idle.
// Timing: a palette load is taken while the block stays idle. In search mode one
// cost unit visits the palette RAM one entry per cycle, palette_size entries
// (at least one); direct mode skips the search. The next request can be taken
// in the cycle after the result is registered.
// A frame_start pixel first sweeps every entry of both error lines.
// After reset the same sweep runs; req_stall is high for its duration.
// The result sits in an output register; when the receiver stalls, the block
// may take the next request but holds a new result until that transfer ends.
module dithering_palette_quantizer_core import dpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  luma,
	input  logic        frame_start,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] pixel_code,
	output logic        row_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	state_t state_q;

	logic       grey_q, direct_q;
	logic [10:0] lw_q;
	logic [8:0]  psize_q;

	logic [COL_BITS-1:0] col_q, clr_q;
	logic                ls_q, pend_q;
	logic [7:0]          r_q, g_q, b_q;
	logic [7:0]          dar_q, dag_q, dab_q, y_q;
	logic [ERR_W-1:0]    res_q;
	logic [15:0]         code_q;

	logic [PAL_BITS:0]     issue_q;
	logic                  rd_vld_s1;
	logic [PAL_BITS-1:0]   rd_idx_s1;
	logic [COST_BITS-1:0]  best_cost_q;
	logic [PAL_BITS-1:0]   best_idx_q;
	logic [31:0]           best_ent_q;

	logic res_valid_q, row_end_q;
	logic [15:0] pixel_code_q;

	// derived geometry
	logic [WID_BITS-1:0] wid;
	logic [COL_BITS-1:0] n, n_p1, n_m1;
	logic                has_right, last;
	logic [PAL_BITS:0]   cnt;

	always_comb begin
		if (lw_q == '0)
			wid = WID_BITS'(1);
		else if (32'(lw_q) > MAX_LINE_WIDTH)
			wid = WID_BITS'(MAX_LINE_WIDTH);
		else
			wid = WID_BITS'(lw_q);
		// a column past the width (width shrank mid-row) acts as the last one
		if ({1'b0, col_q} >= wid)
			n = COL_BITS'(wid - WID_BITS'(1));
		else
			n = col_q;
		n_p1      = n + COL_BITS'(1);
		n_m1      = n - COL_BITS'(1);
		has_right = ({1'b0, n} + WID_BITS'(1)) < wid;
		last      = !has_right;
		if (psize_q == '0)
			cnt = (PAL_BITS+1)'(1);
		else if (32'(psize_q) > PAL_ENTRIES)
			cnt = (PAL_BITS+1)'(PAL_ENTRIES);
		else
			cnt = (PAL_BITS+1)'(psize_q);
	end

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	wire   req_xfer  = req_valid && !req_stall;

	// palette memory
	logic                pal_we;
	logic [PAL_BITS-1:0] pal_raddr;
	logic [31:0]         pal_rdata;

	assign pal_we    = req_xfer && (req_type == REQ_LOAD);
	assign pal_raddr = issue_q[PAL_BITS-1:0];

	dpq_ram #(.WIDTH(32), .DEPTH(PAL_ENTRIES)) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (PAL_BITS'(entry_index)),
		.wdata ({luma, blue, green, red}),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	// error line banks, addressed as current / following by line select
	logic                cur_we, nxt_we;
	logic [COL_BITS-1:0] cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
	logic [ERR_W-1:0]    cur_wdata, nxt_wdata, cur_rdata, nxt_rdata;
	logic                b0_we, b1_we;
	logic [COL_BITS-1:0] b0_waddr, b1_waddr, b0_raddr, b1_raddr;
	logic [ERR_W-1:0]    b0_wdata, b1_wdata, b0_rdata, b1_rdata;

	always_comb begin
		cur_we    = 1'b0;
		nxt_we    = 1'b0;
		cur_waddr = n;
		nxt_waddr = n;
		cur_wdata = '0;
		nxt_wdata = '0;
		cur_raddr = n;
		nxt_raddr = n;
		case (state_q)
			S_CLEAR: begin
				cur_we    = 1'b1;
				nxt_we    = 1'b1;
				cur_waddr = clr_q;
				nxt_waddr = clr_q;
			end
			S_DRD1: begin
				cur_raddr = n_p1;
				nxt_raddr = n_p1;
			end
			S_DWR1: begin
				cur_we    = has_right;
				nxt_we    = has_right;
				cur_waddr = n_p1;
				nxt_waddr = n_p1;
				cur_wdata = spread(cur_rdata, res_q, W_RIGHT);
				nxt_wdata = spread(nxt_rdata, res_q, W_BRIGHT);
			end
			S_DRD2: nxt_raddr = n_m1;
			S_DWR2: begin
				nxt_we    = (n != '0);
				nxt_waddr = n_m1;
				nxt_wdata = spread(nxt_rdata, res_q, W_BLEFT);
			end
			S_DWR3: begin
				cur_we    = 1'b1;
				nxt_we    = 1'b1;
				nxt_wdata = spread(nxt_rdata, res_q, W_BELOW);
			end
			default: ;
		endcase
	end

	always_comb begin
		b0_we    = ls_q ? nxt_we    : cur_we;
		b0_waddr = ls_q ? nxt_waddr : cur_waddr;
		b0_wdata = ls_q ? nxt_wdata : cur_wdata;
		b0_raddr = ls_q ? nxt_raddr : cur_raddr;
		b1_we    = ls_q ? cur_we    : nxt_we;
		b1_waddr = ls_q ? cur_waddr : nxt_waddr;
		b1_wdata = ls_q ? cur_wdata : nxt_wdata;
		b1_raddr = ls_q ? cur_raddr : nxt_raddr;
		cur_rdata = ls_q ? b1_rdata : b0_rdata;
		nxt_rdata = ls_q ? b0_rdata : b1_rdata;
	end

	dpq_ram #(.WIDTH(ERR_W), .DEPTH(MAX_LINE_WIDTH)) u_bank0 (
		.clk   (clk),
		.we    (b0_we),
		.waddr (b0_waddr),
		.wdata (b0_wdata),
		.raddr (b0_raddr),
		.rdata (b0_rdata)
	);

	dpq_ram #(.WIDTH(ERR_W), .DEPTH(MAX_LINE_WIDTH)) u_bank1 (
		.clk   (clk),
		.we    (b1_we),
		.waddr (b1_waddr),
		.wdata (b1_wdata),
		.raddr (b1_raddr),
		.rdata (b1_rdata)
	);

	// shared cost unit
	cost_in_t             cost_pix;
	logic [COST_BITS-1:0] cost;

	assign cost_pix = '{r: dar_q, g: dag_q, b: dab_q, y: y_q, grey: grey_q};

	dpq_cost u_cost (
		.pix   (cost_pix),
		.entry (pal_rdata),
		.cost  (cost)
	);

	// adjusted value: gamma plus diffused error, clamped to 0..255
	function automatic logic [7:0] adjust(input logic [7:0] g, input logic [ERR_BITS-1:0] e);
		logic signed [ERR_BITS+1:0] v;
		v = $signed({2'b00, (ERR_BITS)'(g)}) + (ERR_BITS+2)'($signed(e));
		if (v < 0)
			return 8'd0;
		if (v > (ERR_BITS+2)'(255))
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic logic [ERR_BITS-1:0] diff(input logic [7:0] a, input logic [7:0] b);
		logic signed [9:0] d;
		d = $signed({2'b00, a}) - $signed({2'b00, b});
		return ERR_BITS'(d);
	endfunction

	logic [15:0] ysum;
	assign ysum = 16'(dar_q) * 16'd77 + 16'(dag_q) * 16'd150 + 16'(dab_q) * 16'd29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grey_q   <= 1'b0;
			direct_q <= 1'b0;
			lw_q     <= 11'd320;
			psize_q  <= 9'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GREYSCALE: grey_q   <= cfg_data[0];
				CFG_DIRECT:    direct_q <= cfg_data[0];
				CFG_WIDTH:     lw_q     <= cfg_data;
				CFG_PSIZE:     psize_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			col_q       <= '0;
			ls_q        <= 1'b0;
			pend_q      <= 1'b0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_OUT)
				res_valid_q <= 1'b0;
			rd_vld_s1 <= (state_q == S_SEARCH) && (issue_q < cnt);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + COL_BITS'(1);
					if (clr_q == COL_BITS'(MAX_LINE_WIDTH - 1)) begin
						pend_q  <= 1'b0;
						state_q <= pend_q ? S_RDERR : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_xfer && req_type == REQ_PIXEL) begin
						if (frame_start) begin
							col_q   <= '0;
							ls_q    <= 1'b0;
							clr_q   <= '0;
							pend_q  <= 1'b1;
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_RDERR;
						end
					end
				end
				S_RDERR: state_q <= S_DA;
				S_DA: state_q <= S_PREP;
				S_PREP: begin
					issue_q <= '0;
					state_q <= direct_q ? S_DRD1 : S_SEARCH;
				end
				S_SEARCH: begin
					if (issue_q < cnt) begin
						issue_q <= issue_q + (PAL_BITS+1)'(1);
					end else if (!rd_vld_s1) begin
						state_q <= S_RESID;
					end
				end
				S_RESID: state_q <= S_DRD1;
				S_DRD1:  state_q <= S_DWR1;
				S_DWR1:  state_q <= S_DRD2;
				S_DRD2:  state_q <= S_DWR2;
				S_DWR2:  state_q <= S_DRD3;
				S_DRD3:  state_q <= S_DWR3;
				S_DWR3:  state_q <= S_OUT;
				S_OUT: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						if (last) begin
							col_q <= '0;
							ls_q  <= ~ls_q;
						end else begin
							col_q <= n_p1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q[PAL_BITS-1:0];
		if (req_xfer) begin
			r_q <= red;
			g_q <= green;
			b_q <= blue;
		end
		case (state_q)
			S_DA: begin
				dar_q <= adjust(GAMMA[r_q], cur_rdata[ERR_BITS-1:0]);
				dag_q <= grey_q ? 8'd0 : adjust(GAMMA[g_q], cur_rdata[2*ERR_BITS-1:ERR_BITS]);
				dab_q <= grey_q ? 8'd0 : adjust(GAMMA[b_q], cur_rdata[ERR_W-1:2*ERR_BITS]);
			end
			S_PREP: begin
				y_q         <= ysum[15:8];
				best_cost_q <= '1;
				if (grey_q) begin
					code_q <= {11'd0, dar_q[7:3]};
					res_q  <= {{(2*ERR_BITS){1'b0}}, ERR_BITS'(dar_q[2:0])};
				end else begin
					code_q <= {dar_q[7:3], dag_q[7:2], dab_q[7:3]};
					res_q  <= {ERR_BITS'(dab_q[2:0]), ERR_BITS'(dag_q[1:0]),
						ERR_BITS'(dar_q[2:0])};
				end
			end
			S_SEARCH: begin
				// strict less: lowest index wins ties
				if (rd_vld_s1 && cost < best_cost_q) begin
					best_cost_q <= cost;
					best_idx_q  <= rd_idx_s1;
					best_ent_q  <= pal_rdata;
				end
			end
			S_RESID: begin
				code_q <= 16'(best_idx_q);
				if (grey_q)
					res_q <= {{(2*ERR_BITS){1'b0}}, diff(dar_q, best_ent_q[7:0])};
				else
					res_q <= {diff(dab_q, best_ent_q[23:16]), diff(dag_q, best_ent_q[15:8]),
						diff(dar_q, best_ent_q[7:0])};
			end
			S_OUT: begin
				if (!res_valid_q || !res_stall) begin
					pixel_code_q <= code_q;
					row_end_q    <= last;
				end
			end
			default: ;
		endcase
	end

	assign res_valid  = res_valid_q;
	assign pixel_code = pixel_code_q;
	assign row_end    = row_end_q;

endmodule

>>> sv/dpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/dpq_cost.sv
// Palette match cost unit: luma plus RGB absolute distance, or red distance in greyscale.
module dpq_cost import dpq_pkg::*; (
	input  cost_in_t              pix,
	input  logic [31:0]           entry,
	output logic [COST_BITS-1:0]  cost
);

	function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	logic [7:0] dr, dg, db, dy;

	always_comb begin
		dr = absd(pix.r, entry[7:0]);
		dg = absd(pix.g, entry[15:8]);
		db = absd(pix.b, entry[23:16]);
		dy = absd(pix.y, entry[31:24]);
		if (pix.grey)
			cost = COST_BITS'(dr);
		else
			cost = COST_BITS'(dr) + COST_BITS'(dg) + COST_BITS'(db) + COST_BITS'(dy);
	end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the dithering palette quantizer: directed and random pixels and loads, scoreboard check.
`timescale 1ns / 100ps

module tb_top;
	import dpq_pkg::*;

	localparam int ERRMAX = (1 << (ERR_BITS - 1)) - 1;
	localparam int ERRMIN = -ERRMAX - 1;

	typedef struct {
		logic [15:0] code;
		logic        last;
	} pix_result_t;

	int  mismatches;

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	class dither_scoreboard;
		bit          grey;
		bit          direct;
		int unsigned width;
		int unsigned psize;
		logic [31:0] palette [PAL_ENTRIES];
		int          bank [2][MAX_LINE_WIDTH][3];
		bit          sel;
		int unsigned col;
		pix_result_t pending [$];

		function void clear_lines();
			foreach (bank[b, i, c]) bank[b][i][c] = 0;
		endfunction

		function void init();
			grey = 0; direct = 0; width = 320; psize = 16;
			foreach (palette[i]) palette[i] = '0;
			clear_lines();
			sel = 0; col = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [10:0] val);
			case (idx)
				CFG_GREYSCALE: grey = val[0];
				CFG_DIRECT:    direct = val[0];
				CFG_WIDTH:     width = val;
				CFG_PSIZE:     psize = val[8:0];
				default: ;
			endcase
		endfunction

		function int sat(int v);
			return v > ERRMAX ? ERRMAX : (v < ERRMIN ? ERRMIN : v);
		endfunction

		function int part(int e, int w);
			int m;
			m = ((e < 0 ? -e : e) * w) / 16;
			return e < 0 ? -m : m;
		endfunction

		function int absv(int v);
			return v < 0 ? -v : v;
		endfunction

		function void note_input(bit rtype, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
				logic [7:0] b, logic [7:0] y, bit fs);
			int unsigned wd, n, code, ps, k;
			int          da [3];
			int          rs [3];
			int          best, cost, yd, e;
			logic [7:0]  px [3];
			logic [31:0] ent;
			bit          cs, ns, last;
			if (rtype == REQ_LOAD) begin
				palette[idx] = {y, b, g, r};
				return;
			end
			if (fs) begin
				clear_lines(); col = 0; sel = 0;
			end
			px[0] = r; px[1] = g; px[2] = b;
			wd = width < 1 ? 1 : (width > MAX_LINE_WIDTH ? MAX_LINE_WIDTH : width);
			n = col >= wd ? wd - 1 : col;
			cs = sel; ns = !sel;
			for (int c = 0; c < 3; c++) begin
				da[c] = 0; rs[c] = 0;
			end
			for (int c = 0; c < (grey ? 1 : 3); c++) begin
				e = GAMMA[px[c]] + bank[cs][n][c];
				da[c] = e < 0 ? 0 : (e > 255 ? 255 : e);
			end
			code = 0;
			if (direct) begin
				if (grey) begin
					code = da[0] >> 3;
					rs[0] = da[0] - (code << 3);
				end else begin
					code = ((da[0] >> 3) << 11) | ((da[1] >> 2) << 5) | (da[2] >> 3);
					rs[0] = da[0] & 7; rs[1] = da[1] & 3; rs[2] = da[2] & 7;
				end
			end else begin
				best = 32'h7fffffff;
				yd = (77 * da[0] + 150 * da[1] + 29 * da[2]) >> 8;
				ps = psize > PAL_ENTRIES ? PAL_ENTRIES : psize;
				for (k = 0; k < ps; k++) begin
					ent = palette[k];
					if (grey) cost = absv(da[0] - ent[7:0]);
					else cost = absv(yd - ent[31:24]) + absv(da[0] - ent[7:0]) +
						absv(da[1] - ent[15:8]) + absv(da[2] - ent[23:16]);
					if (cost < best) begin
						best = cost; code = k;
					end
				end
				ent = palette[code];
				rs[0] = da[0] - ent[7:0];
				if (!grey) begin
					rs[1] = da[1] - ent[15:8];
					rs[2] = da[2] - ent[23:16];
				end
			end
			for (int c = 0; c < 3; c++) begin
				e = sat(rs[c]);
				if (n + 1 < wd) begin
					bank[cs][n+1][c] = sat(bank[cs][n+1][c] + part(e, 7));
					bank[ns][n+1][c] = sat(bank[ns][n+1][c] + part(e, 1));
				end
				if (n > 0) bank[ns][n-1][c] = sat(bank[ns][n-1][c] + part(e, 3));
				bank[ns][n][c] = sat(bank[ns][n][c] + part(e, 5));
				bank[cs][n][c] = 0;
			end
			last = (n + 1 >= wd);
			if (last) begin
				col = 0; sel = !sel;
			end else col = n + 1;
			pending.push_back('{code: code[15:0], last: last});
		endfunction

		task check_result(logic [15:0] code, logic last);
			pix_result_t x;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result code=%0h", code));
				return;
			end
			x = pending.pop_front();
			if (code !== x.code)
				report_mismatch($sformatf("pixel_code %0h, want %0h", code, x.code));
			if (last !== x.last)
				report_mismatch($sformatf("row_end %0b, want %0b", last, x.last));
		endtask
	endclass

	logic        clk, arst_n;
	logic        req_valid, req_stall, req_type, frame_start;
	logic [7:0]  entry_index, red, green, blue, luma;
	logic        res_valid, res_stall, row_end;
	logic [15:0] pixel_code;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	dither_scoreboard sb;
	int  idle_pct;

	dithering_palette_quantizer_core dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#80ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stall, check on each transfer
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(pixel_code, row_end);
		res_stall <= ($urandom_range(99) < idle_pct);
	end

	task automatic send(bit t, logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] y, bit fs);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1; req_type <= t; entry_index <= idx; red <= r; green <= g;
		blue <= b; luma <= y; frame_start <= fs;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_input(t, idx, r, g, b, y, fs);
	endtask

	task automatic drain();
		int guard;
		req_valid <= 0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic load_palette(int count);
		for (int i = 0; i < count; i++)
			send(REQ_LOAD, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				1'($urandom));
	endtask

	task automatic rand_pixel(bit fs);
		send(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), fs);
	endtask

	initial begin
		sb = new();
		sb.init();
		mismatches = 0;
		idle_pct = 26;
		arst_n = 0; req_valid = 0; req_type = 0; entry_index = 0; red = 0; green = 0;
		blue = 0; luma = 0; frame_start = 0; res_stall = 0; cfg_valid = 0;
		cfg_index = CFG_GREYSCALE; cfg_data = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: fill all entries, then corner pixels
		load_palette(PAL_ENTRIES);
		send(REQ_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send(REQ_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send(REQ_PIXEL, 0, 0, 0, 0, 0, 1);
		send(REQ_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 0);
		send(REQ_PIXEL, 0, 8'hff, 0, 8'hff, 0, 0);
		send(REQ_PIXEL, 0, 0, 8'hff, 0, 0, 0);
		drain();
		write_reg(CFG_WIDTH, 11'd1);
		write_reg(CFG_PSIZE, 11'd0);
		send(REQ_PIXEL, 0, 8'd200, 8'd100, 8'd50, 0, 1);
		send(REQ_PIXEL, 0, 8'd10, 8'd220, 8'd90, 0, 0);
		drain();
		write_reg(CFG_PSIZE, 11'd511);
		write_reg(CFG_WIDTH, 11'd2047);
		send(REQ_PIXEL, 0, 8'd128, 8'd128, 8'd128, 0, 0);
		drain();
		write_reg(CFG_GREYSCALE, 11'd1);
		write_reg(CFG_DIRECT, 11'd1);
		send(REQ_PIXEL, 0, 8'd255, 8'd3, 8'd7, 0, 1);
		send(REQ_PIXEL, 0, 8'd77, 8'd3, 8'd7, 0, 0);
		drain();
		write_reg(CFG_GREYSCALE, 11'd0);
		send(REQ_PIXEL, 0, 8'd255, 8'd255, 8'd0, 0, 0);
		send(REQ_PIXEL, 0, 8'd99, 8'd1, 8'd254, 0, 0);
		drain();
		// shrink width mid-row: column beyond width ends the row
		write_reg(CFG_DIRECT, 11'd0);
		write_reg(CFG_WIDTH, 11'd8);
		write_reg(CFG_PSIZE, 11'd16);
		for (int i = 0; i < 6; i++) rand_pixel(i == 0);
		drain();
		write_reg(CFG_WIDTH, 11'd3);
		rand_pixel(0);
		rand_pixel(0);
		drain();

		// random phases
		for (int ph = 0; ph < 16; ph++) begin
			int w, ps, cnt;
			idle_pct = (ph == 5) ? 0 : 26;
			w = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 12);
			if (ph == 9) w = 1024;
			if (ph == 10) w = 0;
			ps = $urandom_range(1, 24);
			if (ph == 11) ps = 256;
			if (ph == 12) ps = 1;
			write_reg(CFG_GREYSCALE, 11'($urandom_range(1)));
			write_reg(CFG_DIRECT, 11'($urandom_range(3) == 0));
			write_reg(CFG_WIDTH, 11'(w));
			write_reg(CFG_PSIZE, 11'(ps));
			cnt = (ph == 11) ? 30 : 110;
			for (int i = 0; i < cnt; i++) begin
				if ($urandom_range(19) == 0)
					send(REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 1'($urandom));
				else
					rand_pixel(i == 0 || $urandom_range(49) == 0);
			end
			drain();
		end

		if (sb.pending.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

>>> dithering_palette_quantizer_core.f
sv/dpq_pkg.sv
sv/dpq_ram.sv
sv/dpq_cost.sv
sv/dithering_palette_quantizer_core.sv
bench/tb_top.sv
